// ===== hw/rtl/psrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types and constants of the per-source request rate limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int ADDR_W     = 32;
	localparam int TIME_W     = 32;
	localparam int MS_W       = 16;
	localparam int CNT_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] VERDICT_GOOD     = 2'd0;
	localparam logic [1:0] VERDICT_BAD      = 2'd1;
	localparam logic [1:0] VERDICT_TERRIBLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK   = 2'd3;

	localparam logic [MS_W-1:0]  WINDOW_RST  = 16'd2048;
	localparam logic [MS_W-1:0]  PENALTY_RST = 16'd8192;
	localparam logic [CNT_W-1:0] BAD_RST     = 6'd16;
	localparam logic [CNT_W-1:0] BLOCK_RST   = 6'd32;

	typedef struct packed {
		logic [ADDR_W-1:0] owner;
		logic [TIME_W-1:0] start;
		logic [CNT_W-1:0]  count;
	} slot_t;

	localparam int SLOT_DATA_W = $bits(slot_t);

	typedef struct packed {
		logic [MS_W-1:0]  window_ms;
		logic [MS_W-1:0]  penalty_ms;
		logic [CNT_W-1:0] bad_limit;
		logic [CNT_W-1:0] block_limit;
	} cfg_t;

endpackage

// ===== hw/rtl/psrl_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_req_if
// Request channel: source address and current millisecond time.
// ----------------------------------------------------------------------------
interface psrl_req_if;
	logic                          valid;
	logic                          ready;
	logic [psrl_pkg::ADDR_W-1:0]   source_addr;
	logic [psrl_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, output source_addr, output now_ms, input ready);
	modport sink   (input valid, input source_addr, input now_ms, output ready);
endinterface

// ===== hw/rtl/psrl_vrd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_vrd_if
// Verdict channel: one verdict word per request.
// ----------------------------------------------------------------------------
interface psrl_vrd_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink   (input valid, input verdict, output ready);
endinterface

// ===== hw/rtl/psrl_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_slot_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psrl_slot_ram #(
	parameter int DATA_W = 70,
	parameter int DEPTH  = 64,
	parameter int IDX_W  = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/psrl_judge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_judge
// Slot update and verdict for one request against the current slot entry.
// ----------------------------------------------------------------------------
module psrl_judge (
	input  psrl_pkg::cfg_t                cfg,
	input  logic [psrl_pkg::ADDR_W-1:0]   source_addr,
	input  logic [psrl_pkg::TIME_W-1:0]   now_ms,
	input  psrl_pkg::slot_t               cur,
	output psrl_pkg::slot_t               nxt,
	output logic [1:0]                    verdict
);

	logic [psrl_pkg::TIME_W-1:0]  diff;
	logic                         expired;
	logic [psrl_pkg::CNT_W:0]     cnt_inc;

	assign diff = now_ms - cur.start;
	// negative difference never expires
	assign expired = !diff[psrl_pkg::TIME_W-1]
		&& ((diff[psrl_pkg::TIME_W-2:psrl_pkg::MS_W] != '0)
		|| (diff[psrl_pkg::MS_W-1:0] > cfg.window_ms));
	assign cnt_inc = {1'b0, cur.count} + 1'b1;

	always_comb begin
		nxt     = cur;
		verdict = psrl_pkg::VERDICT_GOOD;
		if (cur.owner != source_addr) begin
			nxt.owner = source_addr;
			nxt.start = now_ms;
			nxt.count = '0;
		end else if (expired) begin
			nxt.start = now_ms;
			nxt.count = '0;
		end else if (cnt_inc > {1'b0, cfg.block_limit}) begin
			nxt.count = cfg.block_limit;
			nxt.start = now_ms + {{(psrl_pkg::TIME_W-psrl_pkg::MS_W){1'b0}}, cfg.penalty_ms};
			verdict   = psrl_pkg::VERDICT_TERRIBLE;
		end else if (cnt_inc > {1'b0, cfg.bad_limit}) begin
			nxt.count = cnt_inc[psrl_pkg::CNT_W-1:0];
			nxt.start = now_ms;
			verdict   = psrl_pkg::VERDICT_BAD;
		end else begin
			nxt.count = cnt_inc[psrl_pkg::CNT_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/per_source_request_rate_limiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_request_rate_limiter_top
// Direct-mapped per-source request counter giving a good/bad/terrible verdict.
// ----------------------------------------------------------------------------
// One request word is taken per cycle and its verdict is loaded into the
// output register as the request leaves the judge stage. Slot state (owner,
// window start, count) lives in a 64-entry RAM with a registered read; the
// request is judged in the cycle after the read and written back as it
// leaves that stage, and the last written entry is forwarded to a following
// request to the same slot, so back-to-back hits on one slot keep the full
// rate. Throughput drops only when the verdict side stalls. Reset clears the
// table at once through one valid flag per slot, so there is no clearing pass.
module per_source_request_rate_limiter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	psrl_req_if.sink                          req,
	psrl_vrd_if.source                        vrd,
	input  logic                              cfg_we,
	input  logic [psrl_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [psrl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	psrl_pkg::cfg_t                 cfg_q;

	logic                           acc;
	logic                           vld_s1;
	logic                           adv_s1;
	logic [psrl_pkg::ADDR_W-1:0]    addr_s1;
	logic [psrl_pkg::TIME_W-1:0]    now_s1;
	logic                           rd_vld_s1;
	logic [psrl_pkg::SLOT_W-1:0]    slot_s1;
	logic [psrl_pkg::SLOT_W-1:0]    req_slot;

	logic [psrl_pkg::SLOT_COUNT-1:0] entry_vld_q;
	logic                           fwd_vld_q;
	logic [psrl_pkg::SLOT_W-1:0]    fwd_slot_q;
	psrl_pkg::slot_t                fwd_data_q;

	logic [psrl_pkg::SLOT_DATA_W-1:0] rdata;
	psrl_pkg::slot_t                cur;
	psrl_pkg::slot_t                nxt;
	logic [1:0]                     verdict;

	logic                           out_vld_q;
	logic [1:0]                     verdict_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms   <= psrl_pkg::WINDOW_RST;
			cfg_q.penalty_ms  <= psrl_pkg::PENALTY_RST;
			cfg_q.bad_limit   <= psrl_pkg::BAD_RST;
			cfg_q.block_limit <= psrl_pkg::BLOCK_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				psrl_pkg::CFG_WINDOW:  cfg_q.window_ms   <= cfg_wdata;
				psrl_pkg::CFG_PENALTY: cfg_q.penalty_ms  <= cfg_wdata;
				psrl_pkg::CFG_BAD:     cfg_q.bad_limit   <= cfg_wdata[psrl_pkg::CNT_W-1:0];
				psrl_pkg::CFG_BLOCK:   cfg_q.block_limit <= cfg_wdata[psrl_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_s1    = vld_s1 && (!out_vld_q || vrd.ready);
	assign req.ready = !vld_s1 || adv_s1;
	assign acc       = req.valid && req.ready;
	assign req_slot  = req.source_addr[psrl_pkg::SLOT_W-1:0];
	assign slot_s1   = addr_s1[psrl_pkg::SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1   <= req.source_addr;
			now_s1    <= req.now_ms;
			rd_vld_s1 <= entry_vld_q[req_slot];
		end
	end

	psrl_slot_ram #(
		.DATA_W (psrl_pkg::SLOT_DATA_W),
		.DEPTH  (psrl_pkg::SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (slot_s1),
		.wdata (nxt),
		.re    (acc),
		.raddr (req_slot),
		.rdata (rdata)
	);

	// the last write is the newest copy of its slot; never-written slots read zero
	always_comb begin
		if (fwd_vld_q && (fwd_slot_q == slot_s1)) begin
			cur = fwd_data_q;
		end else if (rd_vld_s1) begin
			cur = psrl_pkg::slot_t'(rdata);
		end else begin
			cur = '0;
		end
	end

	psrl_judge u_judge (
		.cfg         (cfg_q),
		.source_addr (addr_s1),
		.now_ms      (now_s1),
		.cur         (cur),
		.nxt         (nxt),
		.verdict     (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			fwd_vld_q   <= 1'b0;
		end else if (adv_s1) begin
			entry_vld_q[slot_s1] <= 1'b1;
			fwd_vld_q            <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fwd_slot_q <= slot_s1;
			fwd_data_q <= nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (vrd.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			verdict_q <= verdict;
		end
	end

	assign vrd.valid   = out_vld_q;
	assign vrd.verdict = verdict_q;

	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (verdict_q != 2'd3))
		else $error("verdict code 3 presented");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s1) |-> !acc)
		else $error("request taken while judge stage stalled");

	a_slot_marked: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (entry_vld_q[fwd_slot_q] && fwd_vld_q))
		else $error("written slot not marked valid");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s1) |=> (vld_s1 && $stable(addr_s1) && $stable(now_s1)))
		else $error("stalled request changed");

endmodule

// ===== tb/psrl_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_tb_pkg
// Verdict book: a cycle-free model of the rate limiter's slot table and
// configuration, plus the queue of verdicts still owed by the block.
// ----------------------------------------------------------------------------
package psrl_tb_pkg;

	import psrl_pkg::*;

	class verdict_book;

		logic [ADDR_W-1:0] slot_owner [SLOT_COUNT];
		logic [TIME_W-1:0] slot_start [SLOT_COUNT];
		logic [CNT_W-1:0]  slot_count [SLOT_COUNT];
		cfg_t              cfg;
		logic [1:0]        owed_verdicts [$];
		int                errors;

		function new();
			foreach (slot_owner[i]) begin
				slot_owner[i] = '0;
				slot_start[i] = '0;
				slot_count[i] = '0;
			end
			cfg.window_ms   = WINDOW_RST;
			cfg.penalty_ms  = PENALTY_RST;
			cfg.bad_limit   = BAD_RST;
			cfg.block_limit = BLOCK_RST;
			errors          = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_WINDOW:  cfg.window_ms   = data[MS_W-1:0];
				CFG_PENALTY: cfg.penalty_ms  = data[MS_W-1:0];
				CFG_BAD:     cfg.bad_limit   = data[CNT_W-1:0];
				CFG_BLOCK:   cfg.block_limit = data[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		// Judge one accepted request and queue the verdict it must produce.
		function void note_request(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
			logic [SLOT_W-1:0] s;
			logic [TIME_W-1:0] age;
			logic [CNT_W:0]    hits;
			logic [1:0]        verdict;
			s   = addr[SLOT_W-1:0];
			age = now - slot_start[s];
			if (slot_owner[s] != addr) begin
				slot_owner[s] = addr;
				slot_start[s] = now;
				slot_count[s] = '0;
				verdict       = VERDICT_GOOD;
			end else if (!age[TIME_W-1] && age > {{(TIME_W-MS_W){1'b0}}, cfg.window_ms}) begin
				// window expired; a negative age means a penalty start still in the future
				slot_start[s] = now;
				slot_count[s] = '0;
				verdict       = VERDICT_GOOD;
			end else begin
				hits = {1'b0, slot_count[s]} + 1'b1;
				if (hits > {1'b0, cfg.block_limit}) begin
					slot_count[s] = cfg.block_limit;
					slot_start[s] = now + {{(TIME_W-MS_W){1'b0}}, cfg.penalty_ms};
					verdict       = VERDICT_TERRIBLE;
				end else if (hits > {1'b0, cfg.bad_limit}) begin
					slot_count[s] = hits[CNT_W-1:0];
					slot_start[s] = now;
					verdict       = VERDICT_BAD;
				end else begin
					slot_count[s] = hits[CNT_W-1:0];
					verdict       = VERDICT_GOOD;
				end
			end
			owed_verdicts.push_back(verdict);
		endfunction

		function void check_verdict(logic [1:0] got);
			logic [1:0] want;
			if (owed_verdicts.size() == 0) begin
				$error("verdict: none expected, got %0d", got);
				errors++;
			end else begin
				want = owed_verdicts.pop_front();
				if (got !== want) begin
					$error("verdict: expected %0d, got %0d", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return owed_verdicts.size();
		endfunction

	endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the per-source request rate limiter: directed requests
// over window expiry, negative ages, slot eviction and the limits, then
// random phases of hot-address traffic under several limit settings, with
// random stalls on both channels, checked word by word against a model.
// ----------------------------------------------------------------------------
module testbench;

	import psrl_pkg::*;
	import psrl_tb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	psrl_req_if req_ch ();
	psrl_vrd_if vrd_ch ();

	per_source_request_rate_limiter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.vrd       (vrd_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	verdict_book       book;
	int                cycle_count = 0;
	int                verdict_hold = 0;
	bit                calm = 0;
	logic [TIME_W-1:0] clock_ms;
	logic [ADDR_W-1:0] hot_addr [6];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Verdict side: random stall bursts, plus a long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		vrd_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && vrd_ch.valid && vrd_ch.ready)
				book.check_verdict(vrd_ch.verdict);
			if (verdict_hold > 0) begin
				verdict_hold--;
				vrd_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				vrd_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 10);
				vrd_ch.ready <= 1'b0;
			end else begin
				vrd_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
		req_ch.valid       <= 1'b1;
		req_ch.source_addr <= addr;
		req_ch.now_ms      <= now;
		do @(posedge clk); while (!req_ch.ready);
		book.note_request(addr, now);
	endtask

	task automatic pause_requests(int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold requests until every verdict is back, then let the pipe empty.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(cfg_t c);
		logic [CFG_IDX_W-1:0]  idx  [4];
		logic [CFG_DATA_W-1:0] data [4];
		idx[0]  = CFG_WINDOW;
		idx[1]  = CFG_PENALTY;
		idx[2]  = CFG_BAD;
		idx[3]  = CFG_BLOCK;
		data[0] = c.window_ms;
		data[1] = c.penalty_ms;
		// upper bits of the narrow registers are junk that must be dropped
		data[2] = {10'($urandom), c.bad_limit};
		data[3] = {10'($urandom), c.block_limit};
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= idx[i];
			cfg_wdata <= data[i];
			@(posedge clk);
			book.write_register(idx[i], data[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic hit_series(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] times [$]);
		foreach (times[i])
			send_request(addr, times[i]);
	endtask

	// Mostly hot addresses at a slowly advancing time; the rest evicts
	// hot slots, hits random sources or carries a random time.
	task automatic run_phase(cfg_t c, int hot_n, int jump_odds, int n_items,
			int hold_at, int drain_at);
		int                pick;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] now;
		apply_settings(c);
		for (int k = 0; k < n_items; k++) begin
			if (k == hold_at)
				verdict_hold = 300;
			if (k == drain_at)
				drain();
			if (!calm && $urandom_range(0, 5) == 0)
				pause_requests($urandom_range(1, 11));
			if ($urandom_range(1, jump_odds) == 1)
				clock_ms += $urandom_range(0, int'(c.window_ms) + int'(c.penalty_ms) + 64);
			else
				clock_ms += $urandom_range(0, 3);
			pick = $urandom_range(0, 15);
			addr = hot_addr[$urandom_range(0, hot_n - 1)];
			if (pick >= 14)
				addr = $urandom;
			else if (pick >= 12)
				addr = {26'($urandom), addr[SLOT_W-1:0]};
			now = ($urandom_range(0, 15) == 0) ? TIME_W'($urandom) : clock_ms;
			send_request(addr, now);
		end
	endtask

	initial begin
		logic [TIME_W-1:0] times [$];
		book = new();
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_idx            <= CFG_WINDOW;
		cfg_wdata          <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.source_addr <= '0;
		req_ch.now_ms      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (hot_addr[i])
			hot_addr[i] = $urandom;
		clock_ms = $urandom;

		// address zero hits the cleared slot 0 entry, then negative age and expiry
		send_request(32'h0000_0000, 32'h0000_0000);
		send_request(32'h0000_0000, 32'hFFFF_FFFF);
		send_request(32'h0000_0000, 32'h0000_0801);
		send_request(32'hFFFF_FFFF, 32'h8000_0000);
		send_request(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_request(32'hFFFF_FFC0, 32'h8000_0800);
		send_request(32'h0000_0000, 32'h8000_0801);

		// walk one source through bad, block, future start and expiry
		apply_settings('{window_ms: 16'd100, penalty_ms: 16'd500,
			bad_limit: 6'd2, block_limit: 6'd4});
		times = '{1000, 1001, 1002, 1003, 1004, 1005, 1605, 2206};
		hit_series(32'h5A5A_A5A5, times);

		// bad limit above block limit: never bad, and a zero penalty
		apply_settings('{window_ms: 16'd7, penalty_ms: 16'd0,
			bad_limit: 6'd5, block_limit: 6'd3});
		times = '{3000, 3001, 3002, 3003, 3004};
		hit_series(32'h5A5A_A5A5, times);

		run_phase('{window_ms: WINDOW_RST, penalty_ms: PENALTY_RST,
			bad_limit: BAD_RST, block_limit: BLOCK_RST}, 4, 24, 105, -1, -1);
		run_phase('{window_ms: 16'd0, penalty_ms: 16'd0,
			bad_limit: 6'd0, block_limit: 6'd0}, 3, 8, 105, 30, -1);
		run_phase('{window_ms: 16'hFFFF, penalty_ms: 16'hFFFF,
			bad_limit: 6'd62, block_limit: 6'd63}, 1, 96, 105, -1, -1);
		run_phase('{window_ms: 16'hFFFF, penalty_ms: 16'd0,
			bad_limit: 6'd63, block_limit: 6'd63}, 2, 96, 105, -1, 50);
		// counts left high by the previous phases saturate at the new limit
		run_phase('{window_ms: 16'd300, penalty_ms: 16'hFFFF,
			bad_limit: 6'd5, block_limit: 6'd10}, 6, 32, 105, -1, -1);
		run_phase('{window_ms: 16'd17, penalty_ms: 16'd1000,
			bad_limit: 6'd3, block_limit: 6'd1}, 2, 16, 105, -1, -1);
		calm = 1;
		run_phase('{window_ms: 16'd1000, penalty_ms: 16'd250,
			bad_limit: 6'd8, block_limit: 6'd12}, 3, 32, 105, -1, -1);

		drain();
		repeat (8) @(posedge clk);
		if (book.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/psrl_pkg.sv
hw/rtl/psrl_req_if.sv
hw/rtl/psrl_vrd_if.sv
hw/rtl/psrl_slot_ram.sv
hw/rtl/psrl_judge.sv
hw/rtl/per_source_request_rate_limiter_top.sv
tb/psrl_tb_pkg.sv
tb/testbench.sv
